[rtl/prp_pkg.sv]
package prp_pkg;
    localparam int MAX_PAGES_DEF  = 64;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int AGE_BITS_DEF   = 8;
    localparam int CNT_W          = 16;
    localparam logic [15:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;

    localparam logic [1:0] MODE_NFU    = 2'd0;
    localparam logic [1:0] MODE_RANDOM = 2'd1;
    localparam logic [1:0] MODE_AGING  = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_PAGES = 2'd1;
    localparam logic [1:0] REG_FRAMES = 2'd2;
    localparam logic [1:0] REG_SEED  = 2'd3;
endpackage

[rtl/prp_ram.sv]
module prp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/page_replacement_pager.sv]
// Page replacement pager.
// Input channel (in_valid/in_ready) carries one access word: cmd (0 read,
// 1 write) and page. Output channel (out_valid/out_ready) returns one result
// word per access: hit, frame, evicted, evicted_page, writeback and the
// saturating disk access count. Configuration writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data) set the mode, page and frame counts and the LFSR seed.
// A configuration write is taken only while the block is idle, ahead of a
// waiting access. All page state sits in one synchronous RAM, one entry per
// page, plus a small RAM of frame owners. After reset a clearing pass walks
// all MAX_PAGES entries, one a cycle, before the first access is taken.
// A hit passes through LOOK, DEC and OUT; a fill from a free frame adds LOAD.
// A random eviction computes a bit-serial remainder of the 16-bit LFSR value
// by the allocated frame count. An NFU or aging eviction sweeps every page
// entry through the RAM port once, read-modify-write. One access is handled
// at a time; the next is accepted once the block is back in IDLE after the
// result is loaded. A new access is accepted while the last result still
// waits in the output register, but the next result is held back until the
// receiver takes the previous word.
module page_replacement_pager
    import prp_pkg::*;
#(
    parameter int MAX_PAGES  = MAX_PAGES_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int AGE_BITS   = AGE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [5:0]  page,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [3:0]  frame,
    output logic        evicted,
    output logic [5:0]  evicted_page,
    output logic        writeback,
    output logic [31:0] disk_accesses
);
    localparam int PW = $clog2(MAX_PAGES);
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int KW = (AGE_BITS > CNT_W) ? AGE_BITS : CNT_W;
    // entry: valid, dirty, referenced, frame, use count, age
    localparam int EW = 3 + FW + CNT_W + AGE_BITS;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_DEC    = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_VREAD  = 4'd6;
    localparam logic [3:0] S_VWAIT  = 4'd7;
    localparam logic [3:0] S_EVICT  = 4'd8;
    localparam logic [3:0] S_RWAIT  = 4'd9;
    localparam logic [3:0] S_OWAIT  = 4'd10;
    localparam logic [3:0] S_LOAD   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    typedef struct packed {
        logic                v;
        logic                d;
        logic                r;
        logic [FW-1:0]       f;
        logic [CNT_W-1:0]    cnt;
        logic [AGE_BITS-1:0] age;
    } entry_t;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg;
    logic [6:0]    np_cfg_reg;
    logic [4:0]    nf_cfg_reg;
    logic [15:0]   lfsr_reg;
    logic [NW-1:0] alloc_reg;
    logic [31:0]   disk_reg;
    logic          cmd_reg;
    logic [PW-1:0] page_reg;
    logic [PW-1:0] idx_reg;      // scan address
    logic [NW-1:0] rem_reg;
    logic [3:0]    rbit_reg;
    logic          best_ok_reg;
    logic [KW-1:0] best_reg;
    logic [PW-1:0] victim_reg;
    logic [FW-1:0] frame_res_reg;
    logic          hit_res_reg;
    logic          ev_res_reg;
    logic          wb_res_reg;
    logic [PW-1:0] evp_res_reg;
    logic          ovalid_reg;
    logic          out_hit_reg, out_ev_reg, out_wb_reg;
    logic [3:0]    out_frame_reg;
    logic [5:0]    out_evp_reg;
    logic [31:0]   out_disk_reg;

    logic          pwe;
    logic [PW-1:0] pwaddr, praddr;
    entry_t        pwdata, prdata;
    logic [EW-1:0] prdata_raw;
    logic          fwe;
    logic [FW-1:0] fwaddr, fraddr;
    logic [PW-1:0] fwdata, frdata;

    prp_ram #(.WIDTH(EW), .DEPTH(MAX_PAGES)) u_page_ram (
        .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata),
        .raddr(praddr), .rdata(prdata_raw)
    );
    assign prdata = entry_t'(prdata_raw);

    prp_ram #(.WIDTH(PW), .DEPTH(1 << FW)) u_owner_ram (
        .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata),
        .raddr(fraddr), .rdata(frdata)
    );

    // Clamped register views.
    logic [PW:0]   np_eff;
    logic [NW-1:0] nf_eff;
    always_comb
    begin
        if (np_cfg_reg == 7'd0)
            np_eff = (PW+1)'(1);
        else if (32'(np_cfg_reg) > MAX_PAGES)
            np_eff = (PW+1)'(MAX_PAGES);
        else
            np_eff = (PW+1)'(np_cfg_reg);
        if (nf_cfg_reg == 5'd0)
            nf_eff = NW'(1);
        else if (32'(nf_cfg_reg) > MAX_FRAMES)
            nf_eff = NW'(MAX_FRAMES);
        else
            nf_eff = NW'(nf_cfg_reg);
    end

    // Per-entry update during a sweep, and the key that is compared.
    entry_t        upd;
    logic [KW-1:0] key;
    always_comb
    begin
        upd = prdata;
        if (mode_reg == MODE_NFU)
        begin
            if (prdata.r && prdata.cnt != {CNT_W{1'b1}})
                upd.cnt = prdata.cnt + CNT_W'(1);
            upd.r = 1'b0;
        end
        else if (prdata.v)
        begin
            upd.age = prdata.age >> 1;
            if (prdata.r)
            begin
                upd.age[AGE_BITS-1] = 1'b1;
                upd.r = 1'b0;
            end
        end
        if (mode_reg == MODE_NFU)
            key = KW'(upd.cnt);
        else
            key = KW'(upd.age);
    end

    logic [15:0] lfsr_step;
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    // One step of the restoring remainder, lfsr mod allocated frames, MSB first.
    logic [NW:0]   rem_shift;
    logic [NW-1:0] rem_new;
    always_comb
    begin
        rem_shift = {rem_reg, lfsr_reg[rbit_reg]};
        if (rem_shift >= {1'b0, alloc_reg})
            rem_new = NW'(rem_shift - {1'b0, alloc_reg});
        else
            rem_new = NW'(rem_shift);
    end

    logic in_fire, out_fire, cfg_fire;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = ovalid_reg && out_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    logic [31:0] disk_inc;
    assign disk_inc = (disk_reg != 32'hFFFF_FFFF) ? disk_reg + 32'd1 : disk_reg;

    always_comb
    begin
        state_next = state_reg;
        pwe = 1'b0;
        pwaddr = page_reg;
        pwdata = prdata;
        praddr = page_reg;
        fwe = 1'b0;
        fwaddr = frame_res_reg;
        fwdata = page_reg;
        fraddr = FW'(rem_new);
        case (state_reg)
            S_CLEAR:
            begin
                pwe = 1'b1;
                pwaddr = idx_reg;
                pwdata = '0;
                if (idx_reg == PW'(MAX_PAGES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                praddr = page[PW-1:0];
                if (in_fire)
                begin
                    if ({1'b0, page} < 7'(np_eff) && 32'(page) < MAX_PAGES)
                        state_next = S_LOOK;
                    else
                        state_next = S_OUT;
                end
            end
            S_LOOK:
                state_next = S_DEC;
            S_DEC:
            begin
                if (prdata.v)
                begin
                    pwe = 1'b1;
                    pwdata = prdata;
                    pwdata.r = 1'b1;
                    if (cmd_reg)
                        pwdata.d = 1'b1;
                    state_next = S_OUT;
                end
                else if (alloc_reg < nf_eff)
                    state_next = S_LOAD;
                else if (mode_reg == MODE_RANDOM)
                    state_next = S_RWAIT;
                else
                begin
                    praddr = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The entry read last cycle is written back while the next one is read.
                praddr = idx_reg + PW'(1);
                pwe = 1'b1;
                pwaddr = idx_reg;
                pwdata = upd;
                if (idx_reg == PW'(MAX_PAGES - 1))
                    state_next = S_VREAD;
            end
            S_VREAD:
            begin
                praddr = victim_reg;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                praddr = victim_reg;
                state_next = S_EVICT;
            end
            S_RWAIT:
            begin
                fraddr = FW'(rem_new);
                if (rbit_reg == 4'd0)
                    state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                praddr = frdata;
                state_next = S_VWAIT;
            end
            S_EVICT:
            begin
                pwe = 1'b1;
                pwaddr = victim_reg;
                pwdata = prdata;
                pwdata.v = 1'b0;
                pwdata.d = 1'b0;
                pwdata.r = 1'b0;
                praddr = page_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // page entry was read in LOOK/DEC or after EVICT; counts carry over.
                pwe = 1'b1;
                pwaddr = page_reg;
                pwdata = prdata;
                pwdata.v = 1'b1;
                pwdata.d = 1'b0;
                pwdata.r = 1'b0;
                pwdata.f = frame_res_reg;
                fwe = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            mode_reg    <= MODE_AGING;
            np_cfg_reg  <= 7'd64;
            nf_cfg_reg  <= 5'd16;
            lfsr_reg    <= 16'd44257;
            alloc_reg   <= '0;
            disk_reg    <= '0;
            idx_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg <= cfg_data[1:0];
                    REG_PAGES:  np_cfg_reg <= cfg_data[6:0];
                    REG_FRAMES: nf_cfg_reg <= cfg_data[4:0];
                    REG_SEED:   lfsr_reg <= (cfg_data != 16'd0) ? cfg_data : SEED_DEFAULT;
                    default:    mode_reg <= mode_reg;
                endcase
            end
            if (state_reg == S_OUT && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (out_fire)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                    idx_reg <= idx_reg + PW'(1);
                S_IDLE:
                begin
                    hit_res_reg <= 1'b0;
                    ev_res_reg  <= 1'b0;
                    wb_res_reg  <= 1'b0;
                    evp_res_reg <= '0;
                    frame_res_reg <= '0;
                    if (in_fire)
                    begin
                        cmd_reg  <= cmd;
                        page_reg <= page[PW-1:0];
                    end
                end
                S_DEC:
                begin
                    idx_reg     <= '0;
                    best_ok_reg <= 1'b0;
                    if (prdata.v)
                    begin
                        hit_res_reg   <= 1'b1;
                        frame_res_reg <= prdata.f;
                    end
                    else if (alloc_reg < nf_eff)
                    begin
                        frame_res_reg <= FW'(alloc_reg);
                        alloc_reg     <= alloc_reg + NW'(1);
                        disk_reg      <= disk_inc;
                    end
                    else if (mode_reg == MODE_RANDOM)
                    begin
                        lfsr_reg <= lfsr_step;
                        rem_reg  <= '0;
                        rbit_reg <= 4'd15;
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + PW'(1);
                    if (upd.v && (!best_ok_reg || key < best_reg))
                    begin
                        best_ok_reg <= 1'b1;
                        best_reg    <= key;
                        victim_reg  <= idx_reg;
                    end
                end
                S_RWAIT:
                begin
                    rem_reg  <= rem_new;
                    rbit_reg <= rbit_reg - 4'd1;
                end
                S_OWAIT:
                    victim_reg <= frdata;
                S_EVICT:
                begin
                    ev_res_reg    <= 1'b1;
                    evp_res_reg   <= victim_reg;
                    frame_res_reg <= prdata.f;
                    wb_res_reg    <= prdata.d;
                    if (prdata.d)
                        disk_reg <= (disk_reg >= 32'hFFFF_FFFE) ? 32'hFFFF_FFFF
                                                                 : disk_reg + 32'd2;
                    else
                        disk_reg <= disk_inc;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        out_hit_reg   <= hit_res_reg;
                        out_frame_reg <= 4'(frame_res_reg);
                        out_ev_reg    <= ev_res_reg;
                        out_evp_reg   <= 6'(evp_res_reg);
                        out_wb_reg    <= wb_res_reg;
                        out_disk_reg  <= disk_reg;
                    end
                end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    assign out_valid     = ovalid_reg;
    assign hit           = out_hit_reg;
    assign frame         = out_frame_reg;
    assign evicted       = out_ev_reg;
    assign evicted_page  = out_evp_reg;
    assign writeback     = out_wb_reg;
    assign disk_accesses = out_disk_reg;

`ifndef SYNTHESIS
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(alloc_reg) <= MAX_FRAMES)
        else $error("frame allocation count exceeds frame count");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("access taken while busy");
    a_disk_mono: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> disk_reg >= $past(disk_reg))
        else $error("disk count went down");
    a_wb_needs_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && writeback |-> evicted)
        else $error("writeback without eviction");
`endif
endmodule
